[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the spectrum bar scaler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SDBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SDBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sdbs_pkg.sv]
// Package of the spectrum bar scaler: state type, fixed widths, constants
// and the log2 helper functions. No dependencies.
`timescale 1ns / 1ps

package sdbs_pkg;

   typedef enum logic [2:0] {
      S_LOAD,
      S_PEAK_LEAD,
      S_PEAK_FRAC,
      S_EMIT,
      S_DRAIN
   } sdbs_state_type;

   localparam int MAG_W      = 32;
   localparam int LEAD_W     = 5;
   localparam int FRAC_W     = 8;
   localparam int LOG_W      = LEAD_W + FRAC_W;
   localparam int PROD_W     = 25;
   localparam int DB_W       = PROD_W - FRAC_W;
   localparam int X_W        = 15;
   localparam int P_W        = 21;
   localparam int Q_FULL_W   = 41;
   localparam int RECIP_SHIFT = 32;
   localparam int Q_W        = Q_FULL_W - RECIP_SHIFT;
   localparam int BAR_W      = 6;
   localparam int BIN_W      = 5;

   localparam logic signed [PROD_W-1:0] DB_SCALE      = 25'sd602;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS    = 25'sd255;
   localparam logic signed [DB_W-1:0]   DB_FLOOR      = -17'sd6000;
   localparam logic [P_W-1:0]           BAR_MAX       = 21'd58;
   // ceil(2^32 / 6000): exact floor division for every product below 2^21.
   localparam logic [Q_FULL_W-1:0]      RECIP_DB_SPAN = 41'd715828;

   // Position of the leading one by binary search; zero gives zero.
   function automatic logic [LEAD_W-1:0] lead_of(input logic [MAG_W-1:0] v);
      logic [LEAD_W-1:0] lead;
      logic [MAG_W-1:0]  x;
      lead = '0;
      x    = v;
      if (x[31:16] != '0) begin
         lead[4] = 1'b1;
         x = x >> 16;
      end
      if (x[15:8] != '0) begin
         lead[3] = 1'b1;
         x = x >> 8;
      end
      if (x[7:4] != '0) begin
         lead[2] = 1'b1;
         x = x >> 4;
      end
      if (x[3:2] != '0) begin
         lead[1] = 1'b1;
         x = x >> 2;
      end
      if (x[1]) begin
         lead[0] = 1'b1;
      end
      return lead;
   endfunction

   // The eight bits just below the leading one, zero filled at the bottom.
   function automatic logic [FRAC_W-1:0] frac_of(input logic [MAG_W-1:0] v,
                                                 input logic [LEAD_W-1:0] lead);
      logic [MAG_W+FRAC_W-1:0] t;
      t = {v, {FRAC_W{1'b0}}} >> lead;
      return t[FRAC_W-1:0];
   endfunction

endpackage

[hw/rtl/sdbs_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sdbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/spectrum_db_bar_scaler.sv]
// Top level of the spectrum bar scaler: frame load, peak log and bar pipeline.
// Depends on sdbs_pkg, sdbs_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Ports                                   Transfer
// --------  --------------------------------------  ------------------------------
// request   start, busy, req_magnitude,            start high and busy low
//           req_frame_end
// response  rsp_valid, rsp_bin_index,               every cycle rsp_valid is high
//           rsp_bar_height, rsp_is_fundamental,
//           rsp_last_bar
//
// Each bin of a frame is taken while loading, on a transfer of the request
// channel. After the closing bin the block is busy: S_PEAK_LEAD and S_PEAK_FRAC
// form log2 of the peak, S_EMIT reads the bin memory one entry per cycle and
// S_DRAIN lets the seven pipeline stages drain. Bars leave one per cycle, in
// bin order. Reset is synchronous; memory contents are not cleared, only bins
// written in the current frame are read. The receiver cannot stall the bars.

module spectrum_db_bar_scaler
   import sdbs_pkg::*;
#(
   parameter int NUM_BINS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [MAG_W-1:0]   req_magnitude,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   output logic [BIN_W-1:0]   rsp_bin_index,
   output logic [BAR_W-1:0]   rsp_bar_height,
   output logic               rsp_is_fundamental,
   output logic               rsp_last_bar
);

   localparam int AW   = $clog2(NUM_BINS);
   localparam int CW   = $clog2(NUM_BINS + 1);
   // Stage 0 holds the RAM read, stages 1 to 5 compute, stage 6 is the output.
   localparam int NSTG = 7;

   typedef struct packed {
      logic [AW-1:0] idx;
      logic          last;
   } tag_type;

   // Control state.
   sdbs_state_type state_ff, state_in;
   logic [CW-1:0]    load_count_ff, load_count_in;
   logic [CW-1:0]    frame_len_ff, frame_len_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [MAG_W-1:0] peak_ff, peak_in;
   logic [LEAD_W-1:0] peak_lead_ff;
   logic [LOG_W-1:0]  peak_log_ff;

   logic accept;
   logic frame_done;
   logic issue;
   logic rd_last;
   logic pipe_busy;

   // Pipeline bookkeeping.
   logic [NSTG-1:0] valid_ff;
   tag_type         tag_ff [NSTG];

   // Datapath registers.
   logic [MAG_W-1:0]         mag_a_ff;
   logic [LEAD_W-1:0]        lead_a_ff;
   logic                     zero_a_ff, zero_b_ff, zero_c_ff, zero_d_ff, zero_e_ff;
   logic [LOG_W-1:0]         log_b_ff;
   logic signed [PROD_W-1:0] prod_c_ff, prod_c_in;
   logic [X_W-1:0]           x_d_ff, x_d_in;
   logic [P_W-1:0]           p_e_ff;
   logic [BAR_W-1:0]         bar_ff, bar_in;

   logic signed [LOG_W:0]    diff;
   logic signed [PROD_W-1:0] rounded;
   logic signed [DB_W-1:0]   db;
   logic signed [DB_W-1:0]   db_shift;
   logic [Q_FULL_W-1:0]      q_full;
   logic [Q_W-1:0]           q;

   logic [MAG_W-1:0] ram_rd_data;
   logic [AW+BIN_W-1:0] idx_ext;

   assign accept     = start && !busy;
   assign frame_done = req_frame_end || (load_count_ff == CW'(NUM_BINS - 1));
   assign rd_last    = (rd_idx_ff == CW'(frame_len_ff - 1'b1));
   assign pipe_busy  = (valid_ff[NSTG-2:0] != '0);

   // The memory is written only while loading and read only while emitting,
   // so a read never meets a write to the same entry.
   sdbs_ram #(
      .WIDTH (MAG_W),
      .DEPTH (NUM_BINS)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (load_count_ff[AW-1:0]),
      .wr_data (req_magnitude),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept && frame_done) begin
               state_in = S_PEAK_LEAD;
            end
         end
         S_PEAK_LEAD: state_in = S_PEAK_FRAC;
         S_PEAK_FRAC: state_in = S_EMIT;
         S_EMIT: begin
            if (rd_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!pipe_busy) begin
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // State outputs.
   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      case (state_ff)
         S_LOAD:  busy  = 1'b0;
         S_EMIT:  issue = 1'b1;
         default: begin
            busy  = 1'b1;
            issue = 1'b0;
         end
      endcase
   end

   // Frame counters and running peak.
   always_comb begin
      load_count_in = load_count_ff;
      frame_len_in  = frame_len_ff;
      peak_in       = peak_ff;
      rd_idx_in     = rd_idx_ff;
      if (accept) begin
         if (frame_done) begin
            load_count_in = '0;
            frame_len_in  = CW'(load_count_ff + 1'b1);
         end else begin
            load_count_in = CW'(load_count_ff + 1'b1);
         end
         if (req_magnitude > peak_ff) begin
            peak_in = req_magnitude;
         end
      end
      // The peak log is captured in this state, so the peak can start over.
      if (state_ff == S_PEAK_FRAC) begin
         peak_in   = MAG_W'(1);
         rd_idx_in = '0;
      end
      if (issue) begin
         rd_idx_in = CW'(rd_idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_count_ff <= '0;
         frame_len_ff  <= '0;
         rd_idx_ff     <= '0;
         peak_ff       <= MAG_W'(1);
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         frame_len_ff  <= frame_len_in;
         rd_idx_ff     <= rd_idx_in;
         peak_ff       <= peak_in;
      end
   end

   // Log2 of the peak: leading one first, in S_PEAK_LEAD, then the fraction, in S_PEAK_FRAC.
   always_ff @(posedge clock) begin
      if (state_ff == S_PEAK_LEAD) begin
         peak_lead_ff <= lead_of(peak_ff);
      end
      if (state_ff == S_PEAK_FRAC) begin
         peak_log_ff <= {peak_lead_ff, frac_of(peak_ff, peak_lead_ff)};
      end
   end

   // Valid bits travel with the bin tags down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTG-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= '{idx: rd_idx_ff[AW-1:0], last: rd_last};
      for (int k = 1; k < NSTG; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   // Arithmetic of the stages.
   always_comb begin
      // Difference of Q8 logs, scaled to hundredths of a dB.
      diff      = $signed({1'b0, log_b_ff}) - $signed({1'b0, peak_log_ff});
      prod_c_in = $signed({{(PROD_W - LOG_W - 1){diff[LOG_W]}}, diff}) * DB_SCALE;

      // Divide by 256 truncating toward zero, then clamp at the floor.
      rounded  = prod_c_ff + (prod_c_ff[PROD_W-1] ? ROUND_BIAS : '0);
      db       = rounded[PROD_W-1:FRAC_W];
      db_shift = db - DB_FLOOR;
      if (db < DB_FLOOR) begin
         x_d_in = '0;
      end else begin
         x_d_in = db_shift[X_W-1:0];
      end

      // Divide by the dB span through its reciprocal, clamp at the bar maximum; a zero bin gives zero.
      q_full = Q_FULL_W'(p_e_ff) * RECIP_DB_SPAN;
      q      = q_full[Q_FULL_W-1:RECIP_SHIFT];
      if (zero_e_ff) begin
         bar_in = '0;
      end else if (Q_W'(BAR_MAX) < q) begin
         bar_in = BAR_W'(BAR_MAX);
      end else begin
         bar_in = q[BAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff  <= ram_rd_data;
      lead_a_ff <= lead_of(ram_rd_data);
      zero_a_ff <= (ram_rd_data == '0);

      log_b_ff  <= {lead_a_ff, frac_of(mag_a_ff, lead_a_ff)};
      zero_b_ff <= zero_a_ff;

      prod_c_ff <= prod_c_in;
      zero_c_ff <= zero_b_ff;

      x_d_ff    <= x_d_in;
      zero_d_ff <= zero_c_ff;

      p_e_ff    <= P_W'(x_d_ff) * BAR_MAX;
      zero_e_ff <= zero_d_ff;

      bar_ff    <= bar_in;
   end

   assign idx_ext            = {{BIN_W{1'b0}}, tag_ff[NSTG-1].idx};
   assign rsp_valid          = valid_ff[NSTG-1];
   assign rsp_bin_index      = idx_ext[BIN_W-1:0];
   assign rsp_bar_height     = bar_ff;
   assign rsp_is_fundamental = (tag_ff[NSTG-1].idx == AW'(1));
   assign rsp_last_bar       = tag_ff[NSTG-1].last;

   // A bar only leaves while the block is still busy with its frame.
   `SDBS_ASSERT_IMPLIES(a_rsp_while_busy, clock, reset, rsp_valid, busy, "bar outside emit phase")
   // The closing bin starts the peak step with the load count cleared.
   `SDBS_ASSERT_NEXT(a_end_starts_emit, clock, reset, accept && frame_done, (state_ff == S_PEAK_LEAD) && (load_count_ff == '0), "frame end not taken")
   // The final bar of a frame is followed by a gap.
   `SDBS_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_last_bar, !rsp_valid, "bar after last bar")
   // Emission runs with the peak already restarted for the next frame.
   `SDBS_ASSERT_IMPLIES(a_peak_restarted, clock, reset, state_ff == S_EMIT, peak_ff == MAG_W'(1), "peak not restarted")
   // Bars never exceed the scale.
   `SDBS_ASSERT_IMPLIES(a_bar_range, clock, reset, rsp_valid, rsp_bar_height <= BAR_W'(BAR_MAX), "bar above scale")

endmodule
